### sv/hashed_key_table_linear_probe_macros.svh
// ---------------------------------------------------------------------------
// hashed key table assertion macros
// concurrent assertion helpers clocked on clk_i, held off while rst_ni is low
// ---------------------------------------------------------------------------
`ifndef HASHED_KEY_TABLE_LINEAR_PROBE_MACROS_SVH
`define HASHED_KEY_TABLE_LINEAR_PROBE_MACROS_SVH

`ifndef SYNTHESIS

`define HKTLP_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error(msg);

`define HKTLP_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

`define HKTLP_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`else

`define HKTLP_ASSERT(lbl, prop, msg)

`define HKTLP_ASSERT_SAME(lbl, ante, cons, msg)

`define HKTLP_ASSERT_NEXT(lbl, ante, cons, msg)

`endif

`endif

### sv/hktlp_pkg.sv
// ---------------------------------------------------------------------------
// hktlp_pkg
// shared constants, codes, hash coefficients and control types of the table
// ---------------------------------------------------------------------------
package hktlp_pkg;

  localparam int SLOTS      = 64;
  localparam int KEY_BYTES  = 8;
  localparam int VALUE_BITS = 32;

  localparam int IDX_W       = $clog2(SLOTS);
  localparam int KEY_W       = 64;
  localparam int IN_VALUE_W  = 32;
  localparam int OUT_VALUE_W = 32;
  localparam int BCNT_W      = (KEY_BYTES > 1) ? $clog2(KEY_BYTES) : 1;
  localparam int COEF_IDX_W  = 4;
  localparam int PROD_W      = 72;
  localparam int ACC_W       = 76;
  localparam int HASH_LSB    = 64;

  typedef enum logic [1:0] {
    MODE_INSERT = 2'd0,
    MODE_LOOKUP = 2'd1,
    MODE_REMOVE = 2'd2
  } mode_e;

  typedef enum logic [2:0] {
    ST_INSERTED  = 3'd0,
    ST_UPDATED   = 3'd1,
    ST_FOUND     = 3'd2,
    ST_NOT_FOUND = 3'd3,
    ST_REMOVED   = 3'd4,
    ST_FULL      = 3'd5
  } status_e;

  typedef enum logic [1:0] {
    SLOT_EMPTY = 2'd0,
    SLOT_USED  = 2'd1,
    SLOT_TOMB  = 2'd2
  } slot_e;

  typedef enum logic [1:0] {
    WR_NEW    = 2'd0,
    WR_UPDATE = 2'd1,
    WR_TOMB   = 2'd2
  } wr_sel_e;

  typedef struct packed {
    slot_e                 state;
    logic [KEY_W-1:0]      key;
    logic [VALUE_BITS-1:0] value;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);

  typedef struct packed {
    logic    cap;
    logic    hash_step;
    logic    probe_init;
    logic    rd;
    logic    chk;
    logic    wr;
    wr_sel_e wr_sel;
    logic    res_load;
    status_e res_status;
    logic    res_take_value;
    logic    out_load;
  } dp_cmd_t;

  typedef struct packed {
    mode_e mode;
    logic  hash_last;
    slot_e slot;
    logic  key_match;
    logic  have_free;
    logic  probe_last;
  } dp_stat_t;

  function automatic logic [63:0] coef(input logic [COEF_IDX_W-1:0] idx);
    logic [63:0] c;
    case (idx)
      4'd0:    c = 64'h9e3779b97f4a7c15;
      4'd1:    c = 64'hbf58476d1ce4e5b9;
      4'd2:    c = 64'h94d049bb133111eb;
      4'd3:    c = 64'hd6e8feb86659fd93;
      4'd4:    c = 64'ha5a3564e27f5a1c3;
      4'd5:    c = 64'h8d58ac26afe12e47;
      4'd6:    c = 64'hc3a5c85c97cb3127;
      4'd7:    c = 64'hb492b66fbe98f273;
      4'd8:    c = 64'h9ae16a3b2f90404f;
      default: c = '0;
    endcase
    return c;
  endfunction

  function automatic logic [KEY_W-1:0] key_mask(input logic [KEY_W-1:0] k);
    logic [KEY_W-1:0] m;
    m = '0;
    for (int i = 0; i < KEY_BYTES; i++) begin
      m[8*i +: 8] = 8'hff;
    end
    return k & m;
  endfunction

endpackage

### sv/hktlp_if.sv
// ---------------------------------------------------------------------------
// hktlp request and response channels
// valid/ready channels carrying one request word or one response word
// ---------------------------------------------------------------------------
interface hktlp_req_if;
  logic                               valid;
  logic                               ready;
  logic [1:0]                         mode;
  logic [hktlp_pkg::KEY_W-1:0]        key;
  logic [hktlp_pkg::IN_VALUE_W-1:0]   value;

  modport source (output valid, mode, key, value, input ready);
  modport sink   (input valid, mode, key, value, output ready);
endinterface

interface hktlp_rsp_if;
  logic                               valid;
  logic                               ready;
  logic [2:0]                         status;
  logic [hktlp_pkg::OUT_VALUE_W-1:0]  value_out;

  modport source (output valid, status, value_out, input ready);
  modport sink   (input valid, status, value_out, output ready);
endinterface

### sv/hktlp_ram.sv
// ---------------------------------------------------------------------------
// hktlp_ram
// generic single write port, single read port ram with registered read data
// ---------------------------------------------------------------------------
module hktlp_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

### sv/hktlp_datapath.sv
// ---------------------------------------------------------------------------
// hktlp_datapath
// request registers, byte-serial hash, probe pointer, slot ram and result regs
// ---------------------------------------------------------------------------
module hktlp_datapath (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  hktlp_pkg::dp_cmd_t                cmd_i,
  output hktlp_pkg::dp_stat_t               stat_o,
  input  logic [1:0]                        req_mode_i,
  input  logic [hktlp_pkg::KEY_W-1:0]       req_key_i,
  input  logic [hktlp_pkg::IN_VALUE_W-1:0]  req_value_i,
  output logic [2:0]                        rsp_status_o,
  output logic [hktlp_pkg::OUT_VALUE_W-1:0] rsp_value_out_o
);

  hktlp_pkg::mode_e                     mode_q;
  logic [hktlp_pkg::KEY_W-1:0]          key_q;
  logic [hktlp_pkg::VALUE_BITS-1:0]     value_q;
  logic [hktlp_pkg::ACC_W-1:0]          acc_q;
  logic [hktlp_pkg::BCNT_W-1:0]         bcnt_q;
  logic [hktlp_pkg::IDX_W-1:0]          idx_q;
  logic [hktlp_pkg::IDX_W-1:0]          pcnt_q;
  logic                                 have_free_q;
  logic [hktlp_pkg::IDX_W-1:0]          free_idx_q;
  logic                                 rd_vld_q;
  logic [hktlp_pkg::SLOTS-1:0]          vld_q;
  hktlp_pkg::status_e                   res_status_q;
  logic [hktlp_pkg::OUT_VALUE_W-1:0]    res_value_q;
  hktlp_pkg::status_e                   out_status_q;
  logic [hktlp_pkg::OUT_VALUE_W-1:0]    out_value_q;

  logic [7:0]                           key_byte;
  logic [hktlp_pkg::COEF_IDX_W-1:0]     coef_sel;
  logic [hktlp_pkg::PROD_W-1:0]         prod;
  hktlp_pkg::entry_t                    rd_entry;
  hktlp_pkg::entry_t                    wr_entry;
  logic [hktlp_pkg::IDX_W-1:0]          wr_addr;
  hktlp_pkg::slot_e                     slot;
  logic [hktlp_pkg::ENTRY_W-1:0]        rdata;

  // hash: one key byte times its coefficient per cycle
  assign key_byte = 8'(key_q >> {bcnt_q, 3'b000});
  assign coef_sel = hktlp_pkg::COEF_IDX_W'(bcnt_q) + hktlp_pkg::COEF_IDX_W'(1);
  assign prod     = hktlp_pkg::PROD_W'(hktlp_pkg::coef(coef_sel))
                  * hktlp_pkg::PROD_W'(key_byte);

  assign rd_entry = hktlp_pkg::entry_t'(rdata);
  assign slot     = rd_vld_q ? rd_entry.state : hktlp_pkg::SLOT_EMPTY;

  always_comb begin
    wr_entry.state = hktlp_pkg::SLOT_USED;
    wr_entry.key   = key_q;
    wr_entry.value = value_q;
    wr_addr        = idx_q;
    case (cmd_i.wr_sel)
      hktlp_pkg::WR_NEW: begin
        wr_addr = have_free_q ? free_idx_q : idx_q;
      end
      hktlp_pkg::WR_TOMB: begin
        wr_entry.state = hktlp_pkg::SLOT_TOMB;
        wr_entry.key   = rd_entry.key;
        wr_entry.value = rd_entry.value;
      end
      default: begin
        wr_addr = idx_q;
      end
    endcase
  end

  hktlp_ram #(
    .WIDTH (hktlp_pkg::ENTRY_W),
    .DEPTH (hktlp_pkg::SLOTS)
  ) u_slot_ram (
    .clk_i   (clk_i),
    .we_i    (cmd_i.wr),
    .waddr_i (wr_addr),
    .wdata_i (wr_entry),
    .re_i    (cmd_i.rd),
    .raddr_i (idx_q),
    .rdata_o (rdata)
  );

  // per-slot valid bits: a slot never written reads as empty
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (cmd_i.wr) begin
      vld_q[wr_addr] <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.cap) begin
      mode_q  <= hktlp_pkg::mode_e'(req_mode_i);
      key_q   <= hktlp_pkg::key_mask(req_key_i);
      value_q <= hktlp_pkg::VALUE_BITS'(req_value_i);
      acc_q   <= hktlp_pkg::ACC_W'(hktlp_pkg::coef('0));
      bcnt_q  <= '0;
    end
    if (cmd_i.hash_step) begin
      acc_q  <= acc_q + hktlp_pkg::ACC_W'(prod);
      bcnt_q <= bcnt_q + hktlp_pkg::BCNT_W'(1);
    end
    if (cmd_i.probe_init) begin
      idx_q       <= acc_q[hktlp_pkg::HASH_LSB +: hktlp_pkg::IDX_W];
      pcnt_q      <= '0;
      have_free_q <= 1'b0;
    end
    if (cmd_i.rd) begin
      rd_vld_q <= vld_q[idx_q];
    end
    if (cmd_i.chk) begin
      idx_q  <= idx_q + hktlp_pkg::IDX_W'(1);
      pcnt_q <= pcnt_q + hktlp_pkg::IDX_W'(1);
      if (!have_free_q && slot != hktlp_pkg::SLOT_USED) begin
        have_free_q <= 1'b1;
        free_idx_q  <= idx_q;
      end
    end
    if (cmd_i.res_load) begin
      res_status_q <= cmd_i.res_status;
      res_value_q  <= cmd_i.res_take_value ? hktlp_pkg::OUT_VALUE_W'(rd_entry.value) : '0;
    end
    if (cmd_i.out_load) begin
      out_status_q <= res_status_q;
      out_value_q  <= res_value_q;
    end
  end

  assign stat_o.mode       = mode_q;
  assign stat_o.hash_last  = (bcnt_q == hktlp_pkg::BCNT_W'(hktlp_pkg::KEY_BYTES - 1));
  assign stat_o.slot       = slot;
  assign stat_o.key_match  = (rd_entry.key == key_q);
  assign stat_o.have_free  = have_free_q;
  assign stat_o.probe_last = (pcnt_q == hktlp_pkg::IDX_W'(hktlp_pkg::SLOTS - 1));

  assign rsp_status_o    = out_status_q;
  assign rsp_value_out_o = out_value_q;

endmodule

### sv/hktlp_ctrl.sv
// ---------------------------------------------------------------------------
// hktlp_ctrl
// request sequencer: hash, probe slots one by one, update table, hand off word
// ---------------------------------------------------------------------------
module hktlp_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                req_valid_i,
  output logic                req_ready_o,
  output logic                rsp_valid_o,
  input  logic                rsp_ready_i,
  input  hktlp_pkg::dp_stat_t stat_i,
  output hktlp_pkg::dp_cmd_t  cmd_o
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_HASH,
    S_INIT,
    S_RD,
    S_CHK,
    S_DONE
  } state_e;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;
  logic   hit, miss, free_now;

  assign req_ready_o = (state_q == S_IDLE);
  assign rsp_valid_o = out_valid_q;

  always_comb begin
    state_d     = state_q;
    cmd_o       = '0;
    out_valid_d = out_valid_q && !rsp_ready_i;
    free_now    = stat_i.have_free || stat_i.slot != hktlp_pkg::SLOT_USED;
    hit         = stat_i.slot == hktlp_pkg::SLOT_USED && stat_i.key_match;
    miss        = !hit && (stat_i.probe_last || (stat_i.slot != hktlp_pkg::SLOT_USED &&
                                                 stat_i.slot != hktlp_pkg::SLOT_TOMB));
    case (state_q)
      S_IDLE: begin
        if (req_valid_i) begin
          cmd_o.cap = 1'b1;
          state_d   = S_HASH;
        end
      end
      S_HASH: begin
        cmd_o.hash_step = 1'b1;
        if (stat_i.hash_last) begin
          state_d = S_INIT;
        end
      end
      S_INIT: begin
        if (stat_i.mode inside {hktlp_pkg::MODE_INSERT, hktlp_pkg::MODE_LOOKUP,
                                hktlp_pkg::MODE_REMOVE}) begin
          cmd_o.probe_init = 1'b1;
          state_d          = S_RD;
        end else begin
          cmd_o.res_load   = 1'b1;
          cmd_o.res_status = hktlp_pkg::ST_NOT_FOUND;
          state_d          = S_DONE;
        end
      end
      S_RD: begin
        cmd_o.rd = 1'b1;
        state_d  = S_CHK;
      end
      S_CHK: begin
        cmd_o.chk = 1'b1;
        if (hit) begin
          cmd_o.res_load = 1'b1;
          state_d        = S_DONE;
          case (stat_i.mode)
            hktlp_pkg::MODE_INSERT: begin
              cmd_o.wr         = 1'b1;
              cmd_o.wr_sel     = hktlp_pkg::WR_UPDATE;
              cmd_o.res_status = hktlp_pkg::ST_UPDATED;
            end
            hktlp_pkg::MODE_LOOKUP: begin
              cmd_o.res_status     = hktlp_pkg::ST_FOUND;
              cmd_o.res_take_value = 1'b1;
            end
            hktlp_pkg::MODE_REMOVE: begin
              cmd_o.wr             = 1'b1;
              cmd_o.wr_sel         = hktlp_pkg::WR_TOMB;
              cmd_o.res_status     = hktlp_pkg::ST_REMOVED;
              cmd_o.res_take_value = 1'b1;
            end
            default: begin
              cmd_o.res_status = hktlp_pkg::ST_NOT_FOUND;
            end
          endcase
        end else if (miss) begin
          cmd_o.res_load = 1'b1;
          state_d        = S_DONE;
          if (stat_i.mode == hktlp_pkg::MODE_INSERT) begin
            if (free_now) begin
              cmd_o.wr         = 1'b1;
              cmd_o.wr_sel     = hktlp_pkg::WR_NEW;
              cmd_o.res_status = hktlp_pkg::ST_INSERTED;
            end else begin
              cmd_o.res_status = hktlp_pkg::ST_FULL;
            end
          end else begin
            cmd_o.res_status = hktlp_pkg::ST_NOT_FOUND;
          end
        end else begin
          state_d = S_RD;
        end
      end
      S_DONE: begin
        if (!out_valid_q || rsp_ready_i) begin
          cmd_o.out_load = 1'b1;
          out_valid_d    = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

endmodule

### sv/hashed_key_table_linear_probe.sv
// ---------------------------------------------------------------------------
// hashed_key_table_linear_probe
// open-addressed key/value table with linear probing and tombstones
// ---------------------------------------------------------------------------
// usage
//   req_i carries one request word: mode (insert or update, lookup, remove),
//   a key of up to eight bytes and a value; rsp_o returns one word per request
//   with a status code and the stored value for found or removed keys.
//   a request is taken only while the sequencer is idle. the key is hashed one
//   byte per cycle, then slots are probed one by one, each read through the
//   registered read port of the slot ram and then checked, up to SLOTS slots.
//   the next request is taken in the cycle after the previous word moves to
//   the output register. the output register holds a finished word while the
//   receiver stalls; the next request is hashed and probed meanwhile and waits
//   only to hand off. reset marks every slot empty at once; no clearing pass
//   is needed.
// ---------------------------------------------------------------------------
`include "hashed_key_table_linear_probe_macros.svh"

module hashed_key_table_linear_probe (
  input  logic                clk_i,
  input  logic                rst_ni,
  hktlp_req_if.sink           req_i,
  hktlp_rsp_if.source         rsp_o
);

  hktlp_pkg::dp_cmd_t  cmd;
  hktlp_pkg::dp_stat_t stat;

  hktlp_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_valid_i (req_i.valid),
    .req_ready_o (req_i.ready),
    .rsp_valid_o (rsp_o.valid),
    .rsp_ready_i (rsp_o.ready),
    .stat_i      (stat),
    .cmd_o       (cmd)
  );

  hktlp_datapath u_datapath (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (cmd),
    .stat_o          (stat),
    .req_mode_i      (req_i.mode),
    .req_key_i       (req_i.key),
    .req_value_i     (req_i.value),
    .rsp_status_o    (rsp_o.status),
    .rsp_value_out_o (rsp_o.value_out)
  );

  `HKTLP_ASSERT_NEXT(a_busy_after_accept, req_i.valid && req_i.ready, !req_i.ready, "accepted while busy")
  `HKTLP_ASSERT_SAME(a_write_has_result, cmd.wr, cmd.res_load, "table write without a result")
  `HKTLP_ASSERT_NEXT(a_handoff_shows_word, cmd.out_load, rsp_o.valid, "handoff lost")
  `HKTLP_ASSERT(a_one_phase, $onehot0({cmd.cap, cmd.hash_step, cmd.probe_init, cmd.rd, cmd.chk}), "phases overlap")

endmodule
